### design/prsf_pkg.sv
// Shared types for the PI regulator with setpoint filter: request payloads,
// microcode word layout and the control store.
// No dependencies.
`default_nettype none

package prsf_pkg;

  // Request payloads
  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measure;
  } prsf_in_t;

  typedef struct packed {
    logic signed [31:0] control;
    logic               integrator_frozen;
  } prsf_out_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INT_GAIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FF_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ALPHA      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_MIN    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_MAX    = 3'd5;

  // Sequencer
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] STEP_IDLE = 4'd0;
  localparam logic [StepW-1:0] STEP_LAST = 4'd8;

  typedef enum logic [1:0] {
    MUL_FILT = 2'd0,
    MUL_FF   = 2'd1,
    MUL_P    = 2'd2,
    MUL_I    = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    COND_ALWAYS  = 2'd0,
    COND_IN      = 2'd1,
    COND_OUT     = 2'd2,
    COND_NEVER   = 2'd3
  } cond_e;

  typedef struct packed {
    mul_sel_e         mul_sel;
    cond_e            cond;     // hold the step until this holds
    logic             jump;     // take target instead of step + 1
    logic [StepW-1:0] target;
    logic             ld_in;
    logic             ld_fs;
    logic             ld_err_ff;
    logic             ld_p;
    logic             ld_frz;
    logic             ld_int;
    logic             ld_out;
  } uc_word_t;

  localparam uc_word_t UC_NOP = '{
    mul_sel: MUL_FILT, cond: COND_ALWAYS, jump: 1'b1, target: STEP_IDLE,
    ld_in: 1'b0, ld_fs: 1'b0, ld_err_ff: 1'b0, ld_p: 1'b0,
    ld_frz: 1'b0, ld_int: 1'b0, ld_out: 1'b0};

  // Control store: one word per step
  function automatic uc_word_t uc_rom(input logic [StepW-1:0] step);
    uc_word_t w;
    w = UC_NOP;
    w.jump = 1'b0;
    case (step)
      4'd0: begin
        w.cond  = COND_IN;
        w.ld_in = 1'b1;
      end
      4'd1: w.mul_sel = MUL_FILT;
      4'd2: begin
        w.ld_fs   = 1'b1;
        w.mul_sel = MUL_FF;
      end
      4'd3: w.ld_err_ff = 1'b1;
      4'd4: w.mul_sel = MUL_P;
      4'd5: begin
        w.ld_p    = 1'b1;
        w.mul_sel = MUL_I;
      end
      4'd6: w.ld_frz = 1'b1;
      4'd7: w.ld_int = 1'b1;
      4'd8: begin
        w.cond   = COND_OUT;
        w.ld_out = 1'b1;
        w.jump   = 1'b1;
        w.target = STEP_IDLE;
      end
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/pi_regulator_setpoint_filter_top.sv
// PI regulator with setpoint low-pass, feedforward and clamping anti-windup.
// Depends on prsf_pkg for payload types and the microcode store.
`default_nettype none

// One request runs from acceptance to a result in the output register
// through the nine-step microcode program that shares one signed
// 33x33 multiplier across the filter, feedforward, P and I products. A new
// request is taken only at step 0, so the next one is accepted only after the
// previous result has entered the output register; a stalled result holds the
// sequencer at its last step. Math is Q16.16 data with Q8.24 gains; the
// integrator is 48 bits, and the first request after reset loads the
// setpoint filter with the target. Configuration writes are always taken
// and apply at once, so issue them only while the block is idle.
module pi_regulator_setpoint_filter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire prsf_pkg::prsf_in_t            in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      prsf_pkg::prsf_out_t           out_data_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [prsf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import prsf_pkg::*;

  // Configuration registers
  logic signed [31:0] kp_q, ki_q, kf_q, omin_q, omax_q;
  logic        [16:0] alpha_q;

  // Sequencer
  logic [StepW-1:0] step_q, step_d;
  uc_word_t         uc;
  logic             cond_ok;

  // Datapath
  prsf_in_t           in_q;
  logic signed [31:0] fs_q, fs_d;
  logic               primed_q;
  logic signed [31:0] err_q, err_d;
  logic signed [39:0] ff_q, p_q, inc_q, g40;
  logic signed [47:0] integ_q, integ_d;
  logic               frz_q, frz_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod_q, prod_rnd, acc;
  logic        [16:0] alpha_eff;
  logic signed [32:0] err_diff;
  logic signed [49:0] pre, ctl_sum;
  logic signed [48:0] integ_sum;
  logic signed [31:0] ctl;
  logic               out_valid_q, out_free;
  prsf_out_t          out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= 32'sd16777216;
      ki_q    <= '0;
      kf_q    <= '0;
      alpha_q <= 17'h10000;
      omin_q  <= 32'sh8000_0000;
      omax_q  <= 32'sh7fff_ffff;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PROP_GAIN: kp_q    <= cfg_data_i;
        REG_INT_GAIN:  ki_q    <= cfg_data_i;
        REG_FF_GAIN:   kf_q    <= cfg_data_i;
        REG_ALPHA:     alpha_q <= cfg_data_i[16:0];
        REG_OUT_MIN:   omin_q  <= cfg_data_i;
        REG_OUT_MAX:   omax_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Microcode fetch and step advance
  assign uc       = uc_rom(step_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (uc.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_IN:     cond_ok = in_valid_i;
      COND_OUT:    cond_ok = out_free;
      default:     cond_ok = 1'b0;
    endcase
    step_d = step_q;
    if (cond_ok) begin
      step_d = uc.jump ? uc.target : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o = (uc.cond == COND_IN);

  // Shared multiplier, operand select
  assign alpha_eff = alpha_q[16] ? 17'h10000 : alpha_q;

  always_comb begin
    case (uc.mul_sel)
      MUL_FILT: begin
        mul_a = $signed({16'b0, alpha_eff});
        mul_b = 33'(in_q.target) - 33'(fs_q);
      end
      MUL_FF: begin
        mul_a = 33'(kf_q);
        mul_b = 33'(in_q.target);
      end
      MUL_P: begin
        mul_a = 33'(kp_q);
        mul_b = 33'(err_q);
      end
      MUL_I: begin
        mul_a = 33'(ki_q);
        mul_b = 33'(err_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Gain products: round at bit 24
  assign prod_rnd = prod_q + 64'sd8388608;
  assign g40      = prod_rnd[63:24];

  // Filter: fs + alpha*(target - fs) rounded at bit 16; target if unprimed
  assign acc = {{16{fs_q[31]}}, fs_q, 16'b0} + prod_q + 64'sd32768;

  always_comb begin
    fs_d = (alpha_q[16] || !primed_q) ? in_q.target : acc[47:16];
  end

  // Error, saturated to 32 bits
  assign err_diff = 33'(fs_q) - 33'(in_q.measure);

  always_comb begin
    if (err_diff[32] != err_diff[31]) begin
      err_d = err_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_d = err_diff[31:0];
    end
  end

  // Limit test on the sum ahead of the integrator update
  assign pre = 50'(p_q) + 50'(integ_q) + 50'(ff_q);

  always_comb begin
    frz_d = (omax_q <= omin_q)
         || (pre >= 50'(omax_q) && err_q > 32'sd0)
         || (pre <= 50'(omin_q) && err_q < 32'sd0);
  end

  // Integrator, saturated to 48 bits
  assign integ_sum = 49'(integ_q) + 49'(inc_q);

  always_comb begin
    if (integ_sum[48] != integ_sum[47]) begin
      integ_d = integ_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      integ_d = integ_sum[47:0];
    end
  end

  // Control sum, saturated to 32 bits
  assign ctl_sum = 50'(p_q) + 50'(integ_q) + 50'(ff_q);

  always_comb begin
    if (ctl_sum > 50'sh7fff_ffff) begin
      ctl = 32'sh7fff_ffff;
    end else if (ctl_sum < -50'sh8000_0000) begin
      ctl = 32'sh8000_0000;
    end else begin
      ctl = ctl_sum[31:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    if (uc.ld_in && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (uc.ld_err_ff) begin
      err_q <= err_d;
      ff_q  <= g40;
    end
    if (uc.ld_p) begin
      p_q <= g40;
    end
    if (uc.ld_frz) begin
      inc_q <= g40;
    end
    if (uc.ld_out && out_free) begin
      out_q.control           <= ctl;
      out_q.integrator_frozen <= frz_q;
    end
  end

  // Loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= '0;
      primed_q <= 1'b0;
      integ_q  <= '0;
      frz_q    <= 1'b0;
    end else begin
      if (uc.ld_fs) begin
        fs_q     <= fs_d;
        primed_q <= 1'b1;
      end
      if (uc.ld_frz) begin
        frz_q <= frz_d;
      end
      if (uc.ld_int && !frz_q) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uc.ld_out && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_one_request_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while the sequencer was not idle");

  a_result_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == STEP_LAST)
    else $error("result loaded outside the last step");

  a_frozen_holds_integral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.ld_int && frz_q) |=> $stable(integ_q))
    else $error("integrator moved while frozen");

  a_bad_limits_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.ld_frz && omax_q <= omin_q) |=> frz_q)
    else $error("integrator not frozen with invalid limits");

endmodule

`default_nettype wire
